// ===== hw/rtl/rbsp_pkg.sv =====
// Shared types and constants for the record bank stream parser.
// Holds the item structs, phase and event codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbsp_pkg;

   localparam logic [15:0] BANK_MAGIC      = 16'hCBCB;
   localparam logic [31:0] REC_HDR_BYTES   = 32'd20;
   localparam logic [32:0] BANK_HDR_BYTES  = 33'd6;
   localparam logic [32:0] BANK_ALIGN      = 33'd4;

   localparam int unsigned RSP_QUEUE_DEPTH = 4;
   localparam int unsigned RSP_PTR_BITS    = $clog2(RSP_QUEUE_DEPTH);

   // parser phases
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_SEEK   = 3'd1;
   localparam logic [2:0] PH_BANK   = 3'd2;
   localparam logic [2:0] PH_DONE   = 3'd3;
   localparam logic [2:0] PH_HALT   = 3'd4;

   // result event codes
   localparam logic [1:0] EV_BANK_FOUND  = 2'd0;
   localparam logic [1:0] EV_RECORD_DONE = 2'd1;
   localparam logic [1:0] EV_CORRUPT     = 2'd2;
   localparam logic [1:0] EV_BAD_BANK    = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [47:0] record_position;
      logic [31:0] record_length;
      logic [31:0] bank_offset;
      logic [15:0] bank_length;
      logic [7:0]  bank_kind;
      logic [7:0]  bank_revision;
      logic        last_of_item;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/record_bank_stream_parser.sv =====
// Record bank stream parser: size vote, bank header scan, record end events.
// Depends on rbsp_pkg for item types, phase and event codes.
//
// Usage: bytes of the record stream enter on the req_ channel, one item per
// byte, with restart set on the first byte of a record (it also clears a halt
// after a corrupt record). Events leave on the rsp_ channel: bank header found,
// record complete, corrupt record, bad bank header. One byte causes at most two
// events; last_of_item marks the final event of a byte.
// Latency: with no earlier event waiting, the first event of a byte is presented
// on rsp_ the cycle after its byte is accepted, and a second one once the first is taken.
// Throughput: one byte per cycle. All per-byte work is done between the state
// registers and a four-entry result queue; req_ready drops only when the queue
// holds more than two events, i.e. while the receiver stalls and the queue
// cannot take the two events a byte may cause. Bytes that cause no event never
// wait on the queue draining beyond that.
// Reset: the parser returns to the record header phase at stream offset zero
// and the result queue empties.
`timescale 1ns / 1ps
`default_nettype none

module record_bank_stream_parser
   import rbsp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] byte_ff, byte_in;
   logic [31:0] voted_ff, voted_in;
   logic [31:0] word_a_ff, word_a_in;
   logic [31:0] word_b_ff, word_b_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] next_off_ff, next_off_in;
   logic [47:0] bank_hdr_ff, bank_hdr_in;
   logic [47:0] spos_ff, spos_in;
   logic [47:0] rstart_ff, rstart_in;

   rsp_type     queue_ff [RSP_QUEUE_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_PTR_BITS:0]   count_ff;

   logic        accept;
   logic        pop;
   logic [2:0]  ph;
   logic [31:0] idx;
   logic [47:0] rs;
   logic [7:0]  b;
   logic [31:0] vote;
   logic [31:0] rel_diff;
   logic [2:0]  rel;
   logic        in_window;
   logic [47:0] hdr_new;
   logic [15:0] blen;
   logic [7:0]  bk;
   logic [7:0]  br;
   logic [1:0]  pad;
   logic [32:0] nx_bank;
   logic [32:0] nx_seek;
   logic        fits_first;
   logic        fits_seek;
   logic        fits_bank;

   logic        ev0_v, ev1_v, ev2_v;
   rsp_type     ev0, ev1, ev2;
   rsp_type     res0, res1;
   logic [1:0]  n_res;

   assign accept    = req_valid & req_ready;
   assign pop       = rsp_valid & rsp_ready;
   assign req_ready = (count_ff < (RSP_PTR_BITS+1)'(RSP_QUEUE_DEPTH - 1));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];

   assign b  = req_data.data_byte;
   assign ph = req_data.restart ? PH_HEADER : phase_ff;
   assign idx = req_data.restart ? 32'd0 : byte_ff;
   assign rs  = req_data.restart ? spos_ff : rstart_ff;

   assign rel_diff  = idx - next_off_ff;
   assign in_window = (idx >= next_off_ff) && (rel_diff < 32'd6);
   assign rel       = rel_diff[2:0];
   assign hdr_new   = (rel == 3'd0) ? {40'd0, b}
                                    : (bank_hdr_ff | ({40'd0, b} << {rel, 3'b000}));
   assign blen      = hdr_new[31:16];
   assign bk        = hdr_new[39:32];
   assign br        = hdr_new[47:40];
   assign pad       = 2'd0 - blen[1:0];
   assign nx_bank   = {1'b0, next_off_ff} + {17'd0, blen} + {31'd0, pad};
   assign nx_seek   = {1'b0, next_off_ff} + BANK_ALIGN;
   assign fits_first = ({1'b0, REC_HDR_BYTES} + BANK_HDR_BYTES) <= {1'b0, voted_ff};
   assign fits_seek  = (nx_seek + BANK_HDR_BYTES) <= {1'b0, voted_ff};
   assign fits_bank  = (nx_bank + BANK_HDR_BYTES) <= {1'b0, voted_ff};

   always_comb begin
      vote = 32'd0;
      if (asm_in == word_a_ff || asm_in == word_b_ff) begin
         vote = asm_in;
      end else if (word_a_ff == word_b_ff) begin
         vote = word_a_ff;
      end
   end

   always_comb begin
      phase_in    = ph;
      byte_in     = byte_ff;
      voted_in    = voted_ff;
      word_a_in   = word_a_ff;
      word_b_in   = word_b_ff;
      asm_in      = asm_ff;
      next_off_in = next_off_ff;
      bank_hdr_in = bank_hdr_ff;
      spos_in     = spos_ff + 48'd1;
      rstart_in   = rs;
      ev0_v       = 1'b0;
      ev1_v       = 1'b0;
      ev2_v       = 1'b0;
      ev0         = '0;
      ev1         = '0;
      ev2         = '0;
      ev0.record_position = rs;
      ev1.record_position = rs;
      ev2.record_position = rs;

      if (ph == PH_HALT) begin
         byte_in = idx;
      end else begin
         if (ph == PH_HEADER) begin
            if (idx < 32'd12) begin
               if (idx[1:0] == 2'd0) begin
                  asm_in = {24'd0, b};
               end else begin
                  asm_in = asm_ff | ({24'd0, b} << {idx[1:0], 3'b000});
               end
               if (idx == 32'd3) begin
                  word_a_in = asm_in;
               end else if (idx == 32'd7) begin
                  word_b_in = asm_in;
               end else if (idx == 32'd11) begin
                  if (vote < REC_HDR_BYTES) begin
                     voted_in       = 32'd0;
                     ev0_v          = 1'b1;
                     ev0.event_kind = EV_CORRUPT;
                     phase_in       = PH_HALT;
                  end else begin
                     voted_in = vote;
                  end
               end
            end else if (idx == REC_HDR_BYTES - 32'd1) begin
               next_off_in = REC_HDR_BYTES;
               bank_hdr_in = 48'd0;
               phase_in    = fits_first ? PH_SEEK : PH_DONE;
            end
         end else if ((ph == PH_SEEK || ph == PH_BANK) && in_window) begin
            bank_hdr_in = hdr_new;
            if (rel == 3'd1) begin
               if (hdr_new[15:0] != BANK_MAGIC) begin
                  if (ph == PH_SEEK) begin
                     if (fits_seek) begin
                        next_off_in = nx_seek[31:0];
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end else begin
                     ev0_v             = 1'b1;
                     ev0.event_kind    = EV_BAD_BANK;
                     ev0.record_length = voted_ff;
                     ev0.bank_offset   = next_off_ff;
                     phase_in          = PH_DONE;
                  end
               end else begin
                  phase_in = PH_BANK;
               end
            end else if (rel == 3'd5) begin
               ev0_v             = 1'b1;
               ev0.record_length = voted_ff;
               ev0.bank_offset   = next_off_ff;
               if (blen == 16'd0) begin
                  ev0.event_kind = EV_BAD_BANK;
                  phase_in       = PH_DONE;
               end else begin
                  ev0.event_kind    = EV_BANK_FOUND;
                  ev0.bank_length   = blen;
                  ev0.bank_kind     = bk;
                  ev0.bank_revision = br;
                  if (!fits_bank) begin
                     phase_in = PH_DONE;
                  end else if (blen <= 16'd4) begin
                     next_off_in = nx_bank[31:0];
                     if ({br, bk} != BANK_MAGIC) begin
                        ev1_v             = 1'b1;
                        ev1.event_kind    = EV_BAD_BANK;
                        ev1.record_length = voted_ff;
                        ev1.bank_offset   = nx_bank[31:0];
                        phase_in          = PH_DONE;
                     end else begin
                        bank_hdr_in = {32'd0, br, bk};
                        phase_in    = PH_BANK;
                     end
                  end else begin
                     next_off_in = nx_bank[31:0];
                     phase_in    = PH_BANK;
                  end
               end
            end
         end

         if ((phase_in == PH_SEEK || phase_in == PH_BANK || phase_in == PH_DONE) &&
             (({1'b0, idx} + 33'd1) == {1'b0, voted_ff})) begin
            ev2_v             = 1'b1;
            ev2.event_kind    = EV_RECORD_DONE;
            ev2.record_length = voted_ff;
            phase_in          = PH_HEADER;
            byte_in           = 32'd0;
            rstart_in         = spos_ff + 48'd1;
         end else if (phase_in != PH_HALT) begin
            byte_in = idx + 32'd1;
         end else begin
            byte_in = idx;
         end
      end

      res0  = ev0_v ? ev0 : ev2;
      res1  = ev1_v ? ev1 : ev2;
      n_res = 2'({1'b0, ev0_v} + {1'b0, ev1_v} + {1'b0, ev2_v});
      res0.last_of_item = (n_res == 2'd1);
      res1.last_of_item = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         byte_ff     <= 32'd0;
         voted_ff    <= 32'd0;
         word_a_ff   <= 32'd0;
         word_b_ff   <= 32'd0;
         asm_ff      <= 32'd0;
         next_off_ff <= REC_HDR_BYTES;
         bank_hdr_ff <= 48'd0;
         spos_ff     <= 48'd0;
         rstart_ff   <= 48'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         byte_ff     <= byte_in;
         voted_ff    <= voted_in;
         word_a_ff   <= word_a_in;
         word_b_ff   <= word_b_in;
         asm_ff      <= asm_in;
         next_off_ff <= next_off_in;
         bank_hdr_ff <= bank_hdr_in;
         spos_ff     <= spos_in;
         rstart_ff   <= rstart_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_BITS'(n_res);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_BITS'(1);
         end
         count_ff <= count_ff + (accept ? (RSP_PTR_BITS+1)'(n_res) : '0)
                              - (pop ? (RSP_PTR_BITS+1)'(1) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (accept && n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (accept && n_res == 2'd2) begin
         queue_ff[wr_ptr_ff + RSP_PTR_BITS'(1)] <= res1;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rbsp_checker.sv =====
// Port-level checks for the record bank stream parser, bound to the top level.
// Depends on rbsp_pkg for item types and event codes.
`timescale 1ns / 1ps
`default_nettype none

module rbsp_checker
   import rbsp_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or dropped");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item shown right after reset");

   a_corrupt_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == EV_CORRUPT |->
         rsp_data.record_length == 32'd0 && rsp_data.last_of_item)
      else $error("corrupt record event with length or not last");

   a_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == EV_BANK_FOUND |->
         rsp_data.bank_length != 16'd0 && rsp_data.bank_offset >= REC_HDR_BYTES)
      else $error("bank event with zero size or offset inside record header");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == EV_RECORD_DONE |->
         rsp_data.last_of_item && rsp_data.bank_length == 16'd0)
      else $error("record complete event not last or with bank fields");

endmodule

bind record_bank_stream_parser rbsp_checker u_rbsp_checker (.*);

`default_nettype wire
